@@ src/srta_pkg.sv @@
// Shared types, constants and helper functions for the stereographic radius-to-angle core.
`timescale 1ns / 1ps
package srta_pkg;

  localparam int MAX_COEFFS         = 5;
  localparam int NUM_COEFFS_DEFAULT = 5;
  localparam int FIFO_DEPTH         = 4;
  localparam int DIV_BITS           = 62;
  localparam int MUL_LAT            = 4;
  localparam int CORDIC_PRE         = 5;
  localparam int CORDIC_STEPS       = 30;
  localparam int CORDIC_W           = 36;
  localparam int CORDIC_LAT         = CORDIC_PRE + CORDIC_STEPS + 1;

  localparam logic [2:0] REG_FOCAL = 3'd0;
  localparam logic [2:0] REG_REF   = 3'd1;
  localparam logic [2:0] REG_COEF0 = 3'd2;

  localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic signed [63:0] WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef logic signed [63:0] fix_t;
  typedef logic [MAX_COEFFS-1:0][31:0] coef_vec_t;

  typedef struct packed {
    logic [31:0] radius;
    logic        err;
  } item_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    unique case (i)
      0: r = 32'd843314857;
      1: r = 32'd497837829;
      2: r = 32'd263043837;
      3: r = 32'd133525159;
      4: r = 32'd67021687;
      5: r = 32'd33543516;
      6: r = 32'd16775851;
      7: r = 32'd8388437;
      8: r = 32'd4194283;
      9: r = 32'd2097149;
      default: r = 32'd1 << (30 - i);
    endcase
    return r;
  endfunction

endpackage

@@ src/srta_fifo.sv @@
// Small queue between the intake side and the compute pipeline.
`timescale 1ns / 1ps
module srta_fifo #(
  parameter int W     = 33,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         nonempty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/srta_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module srta_div #(
  parameter int NB = 62,
  parameter int DB = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] dividend,
  input  logic [DB-1:0] divisor,
  output logic [NB-1:0] quotient
);

  logic [DB-1:0] rem_s [NB+1];
  logic [NB-1:0] quo_s [NB+1];
  logic [NB-1:0] dvd_s [NB+1];
  logic [DB-1:0] dvs_s [NB+1];

  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign dvd_s[0] = dividend;
  assign dvs_s[0] = divisor;

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [DB:0]   trial;
    logic [DB:0]   diff;
    logic          ge;
    logic [DB-1:0] rem_r;
    logic [NB-1:0] quo_r;
    logic [NB-1:0] dvd_r;
    logic [DB-1:0] dvs_r;

    assign trial = {rem_s[i], dvd_s[i][NB-1-i]};
    assign diff  = trial - {1'b0, dvs_s[i]};
    assign ge    = (trial >= {1'b0, dvs_s[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? diff[DB-1:0] : trial[DB-1:0];
        quo_r <= {quo_s[i][NB-2:0], ge};
        dvd_r <= dvd_s[i];
        dvs_r <= dvs_s[i];
      end
    end

    assign rem_s[i+1] = rem_r;
    assign quo_s[i+1] = quo_r;
    assign dvd_s[i+1] = dvd_r;
    assign dvs_s[i+1] = dvs_r;
  end

  assign quotient = quo_s[NB];

endmodule

@@ src/srta_mul.sv @@
// Pipelined signed Q.30 multiplier with truncated magnitude and saturation.
`timescale 1ns / 1ps
module srta_mul (
  input  logic          clk,
  input  logic          en,
  input  srta_pkg::fix_t a,
  input  srta_pkg::fix_t b,
  output srta_pkg::fix_t p
);

  srta_pkg::fix_t neg_a;
  srta_pkg::fix_t neg_b;
  logic [61:0]    x_q;
  logic [61:0]    y_q;
  logic           neg1;
  logic [63:0]    ll_q;
  logic [61:0]    lh_q;
  logic [61:0]    hl_q;
  logic [59:0]    hh_q;
  logic           neg2;
  logic [123:0]   prod_q;
  logic           neg3;
  logic [61:0]    m;
  srta_pkg::fix_t mag;

  assign neg_a = -a;
  assign neg_b = -b;

  always_ff @(posedge clk) begin
    if (en) begin
      x_q    <= a[63] ? neg_a[61:0] : a[61:0];
      y_q    <= b[63] ? neg_b[61:0] : b[61:0];
      neg1   <= a[63] ^ b[63];
      ll_q   <= 64'(x_q[31:0]) * 64'(y_q[31:0]);
      lh_q   <= 62'(x_q[31:0]) * 62'(y_q[61:32]);
      hl_q   <= 62'(x_q[61:32]) * 62'(y_q[31:0]);
      hh_q   <= 60'(x_q[61:32]) * 60'(y_q[61:32]);
      neg2   <= neg1;
      prod_q <= {60'b0, ll_q} + {30'b0, lh_q, 32'b0} + {30'b0, hl_q, 32'b0}
                + {hh_q, 64'b0};
      neg3   <= neg2;
      p      <= neg3 ? -mag : mag;
    end
  end

  assign m   = (|prod_q[123:92]) ? srta_pkg::WMAX[61:0] : prod_q[91:30];
  assign mag = {2'b00, m};

endmodule

@@ src/srta_cordic.sv @@
// Pipelined arctangent: range prescale then CORDIC vectoring, doubled and clamped.
`timescale 1ns / 1ps
module srta_cordic (
  input  logic           clk,
  input  logic           en,
  input  srta_pkg::fix_t v,
  output logic [31:0]    angle
);

  localparam int PRE   = srta_pkg::CORDIC_PRE;
  localparam int STEPS = srta_pkg::CORDIC_STEPS;
  localparam int W     = srta_pkg::CORDIC_W;
  localparam int ZW    = 34;

  logic [61:0]          py [PRE+1];
  logic [30:0]          px [PRE+1];
  logic signed [W-1:0]  cx [STEPS+1];
  logic signed [W-1:0]  cy [STEPS+1];
  logic signed [ZW-1:0] cz [STEPS+1];
  logic                 pos_q [PRE+STEPS];
  logic signed [ZW:0]   dbl;

  assign py[0] = v[61:0];
  assign px[0] = 31'h4000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_q[0] <= !v[63] && (v != '0);
      for (int j = 1; j < PRE + STEPS; j++) begin
        pos_q[j] <= pos_q[j-1];
      end
    end
  end

  for (genvar k = 0; k < PRE; k++) begin : g_pre
    localparam int AMT = 1 << (PRE - 1 - k);
    logic        big;
    logic [61:0] y_r;
    logic [30:0] x_r;

    assign big = |py[k][61:31+AMT];

    always_ff @(posedge clk) begin
      if (en) begin
        y_r <= big ? (py[k] >> AMT) : py[k];
        x_r <= big ? (px[k] >> AMT) : px[k];
      end
    end

    assign py[k+1] = y_r;
    assign px[k+1] = x_r;
  end

  assign cx[0] = $signed({{(W-31){1'b0}}, px[PRE]});
  assign cy[0] = $signed({{(W-32){1'b0}}, py[PRE][31:0]});
  assign cz[0] = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;
    logic signed [ZW-1:0] ang;
    logic signed [W-1:0]  x_r;
    logic signed [W-1:0]  y_r;
    logic signed [ZW-1:0] z_r;

    assign dx  = cy[i] >>> i;
    assign dy  = cx[i] >>> i;
    assign ang = $signed({2'b00, srta_pkg::atan_q30(i)});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][W-1]) begin
          x_r <= cx[i] + dx;
          y_r <= cy[i] - dy;
          z_r <= cz[i] + ang;
        end else begin
          x_r <= cx[i] - dx;
          y_r <= cy[i] + dy;
          z_r <= cz[i] - ang;
        end
      end
    end

    assign cx[i+1] = x_r;
    assign cy[i+1] = y_r;
    assign cz[i+1] = z_r;
  end

  assign dbl = {cz[STEPS], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      if (!pos_q[PRE+STEPS-1] || dbl[ZW]) begin
        angle <= '0;
      end else if (dbl > $signed({3'b000, srta_pkg::PI_Q30})) begin
        angle <= srta_pkg::PI_Q30;
      end else begin
        angle <= dbl[31:0];
      end
    end
  end

endmodule

@@ src/srta_back.sv @@
// Compute pipeline: divisions, odd polynomial, scaling and arctangent.
`timescale 1ns / 1ps
module srta_back #(
  parameter int NUM_COEFFS = srta_pkg::NUM_COEFFS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  srta_pkg::item_t     head,
  input  logic                head_valid,
  output logic                pop,
  input  logic [31:0]         focal_length,
  input  logic [31:0]         reference_focal,
  input  srta_pkg::coef_vec_t coefs,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [31:0]         angle,
  output logic                config_error
);

  localparam int D   = srta_pkg::DIV_BITS;
  localparam int M   = srta_pkg::MUL_LAT;
  localparam int S   = M + 1;
  localparam int QD  = 2 * M + NUM_COEFFS * S;
  localparam int LAT = D + 3 * M + NUM_COEFFS * S + srta_pkg::CORDIC_LAT;

  function automatic srta_pkg::fix_t sat_add(input srta_pkg::fix_t a, input srta_pkg::fix_t b);
    srta_pkg::fix_t s;
    s = a + b;
    if (s > srta_pkg::WMAX) begin
      return srta_pkg::WMAX;
    end else if (s < -srta_pkg::WMAX) begin
      return -srta_pkg::WMAX;
    end
    return s;
  endfunction

  logic           en;
  logic           vld [LAT];
  logic           err [LAT];
  logic [D-1:0]   u_quo;
  logic [D-1:0]   q_quo;
  srta_pkg::fix_t u;
  srta_pkg::fix_t q;
  srta_pkg::fix_t u_dly [2*M];
  srta_pkg::fix_t q_dly [QD];
  srta_pkg::fix_t t_stage [NUM_COEFFS+1];
  srta_pkg::fix_t v;
  logic [31:0]    ang;

  assign en        = !vld[LAT-1] || rsp_ready;
  assign pop       = en && head_valid;
  assign rsp_valid = vld[LAT-1];
  assign config_error = err[LAT-1];
  assign angle     = err[LAT-1] ? '0 : ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LAT; j++) begin
        vld[j] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= head_valid;
      for (int j = 1; j < LAT; j++) begin
        vld[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err[0] <= head.err;
      for (int j = 1; j < LAT; j++) begin
        err[j] <= err[j-1];
      end
    end
  end

  srta_div #(.NB(D), .DB(32)) u_div (
    .clk      (clk),
    .en       (en),
    .dividend ({head.radius, 30'b0}),
    .divisor  (reference_focal),
    .quotient (u_quo)
  );

  srta_div #(.NB(D), .DB(32)) q_div (
    .clk      (clk),
    .en       (en),
    .dividend ({1'b0, reference_focal, 29'b0}),
    .divisor  (focal_length),
    .quotient (q_quo)
  );

  assign u = {2'b00, u_quo};
  assign q = {2'b00, q_quo};

  always_ff @(posedge clk) begin
    if (en) begin
      u_dly[0] <= u;
      for (int j = 1; j < 2 * M; j++) begin
        u_dly[j] <= u_dly[j-1];
      end
      q_dly[0] <= q;
      for (int j = 1; j < QD; j++) begin
        q_dly[j] <= q_dly[j-1];
      end
    end
  end

  assign t_stage[0] = u_dly[2*M-1];

  if (NUM_COEFFS > 0) begin : g_poly
    srta_pkg::fix_t u2;
    srta_pkg::fix_t p0;
    srta_pkg::fix_t u_m  [M];
    srta_pkg::fix_t u2_m [M];
    srta_pkg::fix_t p_stage [NUM_COEFFS];
    srta_pkg::fix_t w_stage [NUM_COEFFS];

    srta_mul u_sq (.clk(clk), .en(en), .a(u), .b(u), .p(u2));
    srta_mul u_cube (.clk(clk), .en(en), .a(u_m[M-1]), .b(u2), .p(p0));

    always_ff @(posedge clk) begin
      if (en) begin
        u_m[0]  <= u;
        u2_m[0] <= u2;
        for (int j = 1; j < M; j++) begin
          u_m[j]  <= u_m[j-1];
          u2_m[j] <= u2_m[j-1];
        end
      end
    end

    assign p_stage[0] = p0;
    assign w_stage[0] = u2_m[M-1];

    for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_step
      srta_pkg::fix_t coef_x;
      srta_pkg::fix_t term;
      srta_pkg::fix_t t_m [M];
      srta_pkg::fix_t t_r;

      assign coef_x = {{32{coefs[k][31]}}, coefs[k]};

      srta_mul term_mul (.clk(clk), .en(en), .a(coef_x), .b(p_stage[k]), .p(term));

      always_ff @(posedge clk) begin
        if (en) begin
          t_m[0] <= t_stage[k];
          for (int j = 1; j < M; j++) begin
            t_m[j] <= t_m[j-1];
          end
          t_r <= sat_add(t_m[M-1], term);
        end
      end

      assign t_stage[k+1] = t_r;

      if (k < NUM_COEFFS - 1) begin : g_next
        srta_pkg::fix_t pn;
        srta_pkg::fix_t p_r;
        srta_pkg::fix_t w_s [S];

        srta_mul pow_mul (.clk(clk), .en(en), .a(p_stage[k]), .b(w_stage[k]), .p(pn));

        always_ff @(posedge clk) begin
          if (en) begin
            p_r    <= pn;
            w_s[0] <= w_stage[k];
            for (int j = 1; j < S; j++) begin
              w_s[j] <= w_s[j-1];
            end
          end
        end

        assign p_stage[k+1] = p_r;
        assign w_stage[k+1] = w_s[S-1];
      end
    end
  end

  srta_mul v_mul (
    .clk (clk),
    .en  (en),
    .a   (t_stage[NUM_COEFFS]),
    .b   (q_dly[QD-1]),
    .p   (v)
  );

  srta_cordic atan_unit (
    .clk   (clk),
    .en    (en),
    .v     (v),
    .angle (ang)
  );

endmodule

@@ src/stereographic_radius_to_angle_core.sv @@
// Top level of the stereographic radius-to-angle core: registers, intake, queue, pipeline.
`timescale 1ns / 1ps
// Takes one radius (unsigned Q16.16) per clock while the queue is not full and returns the
// stereographic incidence angle (unsigned Q2.30 radians) with odd-power distortion. Each
// transaction passes a fully pipelined datapath: 62-stage restoring dividers for r/f0 and
// f0/(2f), one four-stage multiplier per power and per term, one saturating add per
// coefficient, a five-stage prescale and a 30-stage CORDIC. A four-entry
// queue sits between intake and pipeline; the pipeline holds while a result is not taken.
// config_error flags a zero focal register and then forces the angle to zero. Registers sit
// on an APB-style port at byte addresses 0 (focal_length), 4 (reference_focal) and
// 8..24 (coef_0..coef_4); change them only when the core is idle.
module stereographic_radius_to_angle_core #(
  parameter int NUM_COEFFS = srta_pkg::NUM_COEFFS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [31:0] radius,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] angle,
  output logic        config_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]         focal_length;
  logic [31:0]         reference_focal;
  srta_pkg::coef_vec_t coefs;
  logic [2:0]          idx;
  logic [2:0]          coef_idx;
  logic                wr;
  logic                full;
  logic                push;
  srta_pkg::item_t     in_item;
  logic [$bits(srta_pkg::item_t)-1:0] fifo_dout;
  srta_pkg::item_t     head;
  logic                head_valid;
  logic                pop;

  assign pready   = 1'b1;
  assign idx      = paddr[4:2];
  assign coef_idx = idx - srta_pkg::REG_COEF0;
  assign wr       = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length    <= srta_pkg::FOCAL_RESET;
      reference_focal <= srta_pkg::FOCAL_RESET;
      coefs           <= '0;
    end else if (wr) begin
      priority if (idx == srta_pkg::REG_FOCAL) begin
        focal_length <= pwdata;
      end else if (idx == srta_pkg::REG_REF) begin
        reference_focal <= pwdata;
      end else if (coef_idx < 3'(srta_pkg::MAX_COEFFS)) begin
        coefs[coef_idx] <= pwdata;
      end
    end
  end

  always_comb begin
    priority if (idx == srta_pkg::REG_FOCAL) begin
      prdata = focal_length;
    end else if (idx == srta_pkg::REG_REF) begin
      prdata = reference_focal;
    end else if (coef_idx < 3'(srta_pkg::MAX_COEFFS)) begin
      prdata = coefs[coef_idx];
    end else begin
      prdata = '0;
    end
  end

  assign req_ready      = !full;
  assign push           = req_valid && req_ready;
  assign in_item.radius = radius;
  assign in_item.err    = (focal_length == '0) || (reference_focal == '0);

  srta_fifo #(
    .W     ($bits(srta_pkg::item_t)),
    .DEPTH (srta_pkg::FIFO_DEPTH)
  ) queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (in_item),
    .full     (full),
    .pop      (pop),
    .dout     (fifo_dout),
    .nonempty (head_valid)
  );

  assign head = fifo_dout;

  srta_back #(.NUM_COEFFS(NUM_COEFFS)) back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .focal_length    (focal_length),
    .reference_focal (reference_focal),
    .coefs           (coefs),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .angle           (angle),
    .config_error    (config_error)
  );

endmodule

@@ tb/sv/tb_stereographic_radius_to_angle_core.sv @@
// Testbench for the stereographic radius-to-angle core: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps
module tb_stereographic_radius_to_angle_core;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int LONG_HOLD      = 600;

  typedef struct {
    logic [31:0] angle;
    logic        err;
  } angle_rsp_t;

  class angle_scoreboard;
    logic [31:0]        focal;
    logic [31:0]        ref_focal;
    srta_pkg::fix_t     coef[srta_pkg::MAX_COEFFS];
    angle_rsp_t         pending[$];
    int                 errors;
    logic signed [63:0] atan_tab[10];

    function new();
      focal = srta_pkg::FOCAL_RESET;
      ref_focal = srta_pkg::FOCAL_RESET;
      foreach (coef[k]) coef[k] = 0;
      errors = 0;
      atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149};
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      if (idx == int'(srta_pkg::REG_FOCAL)) focal = v;
      else if (idx == int'(srta_pkg::REG_REF)) ref_focal = v;
      else if (idx >= int'(srta_pkg::REG_COEF0) &&
               idx < int'(srta_pkg::REG_COEF0) + srta_pkg::MAX_COEFFS)
        coef[idx - int'(srta_pkg::REG_COEF0)] = srta_pkg::fix_t'(signed'(v));
    endfunction

    function srta_pkg::fix_t qmul(srta_pkg::fix_t a, srta_pkg::fix_t b);
      logic           neg;
      logic [63:0]    x, y;
      logic [127:0]   p;
      srta_pkg::fix_t m;
      neg = (a < 0) != (b < 0);
      x = (a < 0) ? -a : a;
      y = (b < 0) ? -b : b;
      p = {64'b0, x} * {64'b0, y};
      if (p[127:92] != 0) m = srta_pkg::WMAX;
      else m = srta_pkg::fix_t'({2'b0, p[91:30]});
      return neg ? -m : m;
    endfunction

    function srta_pkg::fix_t sat_sum(srta_pkg::fix_t a, srta_pkg::fix_t b);
      srta_pkg::fix_t s;
      s = a + b;
      if (s > srta_pkg::WMAX) return srta_pkg::WMAX;
      if (s < -srta_pkg::WMAX) return -srta_pkg::WMAX;
      return s;
    endfunction

    function srta_pkg::fix_t atan_vec(logic [63:0] v);
      logic [63:0] ux, uy;
      srta_pkg::fix_t x, y, z, ang, dx, dy;
      ux = 64'd1 << 30;
      uy = v;
      z = 0;
      while (uy >= 64'h1_0000_0000) begin
        ux = ux >> 1;
        uy = uy >> 1;
      end
      x = srta_pkg::fix_t'(ux);
      y = srta_pkg::fix_t'(uy);
      for (int i = 0; i < srta_pkg::CORDIC_STEPS; i++) begin
        ang = (i < 10) ? atan_tab[i] : (srta_pkg::fix_t'(1) <<< (30 - i));
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ang;
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ang;
        end
      end
      return z;
    endfunction

    function void note_radius(logic [31:0] r);
      angle_rsp_t     e;
      logic [63:0]    num;
      srta_pkg::fix_t u, u2, p, t, q, v, ang;
      if (focal == 0 || ref_focal == 0) begin
        e.angle = 0;
        e.err = 1;
      end else begin
        num = {32'b0, r} << 30;
        u = srta_pkg::fix_t'(num / {32'b0, ref_focal});
        u2 = qmul(u, u);
        p = qmul(u, u2);
        t = u;
        for (int k = 0; k < srta_pkg::NUM_COEFFS_DEFAULT; k++) begin
          t = sat_sum(t, qmul(coef[k], p));
          p = qmul(p, u2);
        end
        num = {32'b0, ref_focal} << 29;
        q = srta_pkg::fix_t'(num / {32'b0, focal});
        v = qmul(t, q);
        if (v <= 0) begin
          ang = 0;
        end else begin
          ang = 2 * atan_vec(v);
          if (ang < 0) ang = 0;
          if (ang > srta_pkg::fix_t'(srta_pkg::PI_Q30)) ang = srta_pkg::fix_t'(srta_pkg::PI_Q30);
        end
        e.angle = ang[31:0];
        e.err = 0;
      end
      pending.insert(pending.size(), e);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] a, logic err);
      angle_rsp_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result angle=%0d err=%0b", a, err));
      end else begin
        e = pending.pop_front();
        if (a !== e.angle)
          report($sformatf("angle got %0d exp %0d", a, e.angle));
        if (err !== e.err)
          report($sformatf("config_error got %0b exp %0b", err, e.err));
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_ready;
  logic [31:0] radius = 0;
  logic        rsp_valid;
  logic        rsp_ready = 0;
  logic [31:0] angle;
  logic        config_error;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  angle_scoreboard sb = new();
  bit hold_req = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  stereographic_radius_to_angle_core DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .radius(radius),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .angle(angle), .config_error(config_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(angle, config_error);
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int mode;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        rsp_ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 0;
      end
      mode = $urandom_range(0, 3);
      for (int c = 0; c < 64 && !hold_req; c++) begin
        case (mode)
          0: rsp_ready = 1;
          1: rsp_ready = $urandom_range(0, 1);
          2: rsp_ready = ($urandom_range(0, 9) != 0);
          default: rsp_ready = (c % 5) < 2;
        endcase
        @(negedge clk);
      end
    end
  end

  task write_reg(int idx, logic [31:0] v);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = 5'(idx * 4);
    pwdata = v;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task send_radius(logic [31:0] r);
    @(negedge clk);
    req_valid = 1;
    radius = r;
    do @(posedge clk); while (!req_ready);
    sb.note_radius(r);
  endtask

  task pause_sender(int n);
    @(negedge clk);
    req_valid = 0;
    radius = $urandom;
    repeat (n) @(negedge clk);
  endtask

  task wait_drained();
    pause_sender(1);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0002_0000);
      2: return $urandom_range(0, 32'h0000_1000);
      3: return $urandom_range(32'h0000_8000, 32'h0001_8000);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      2: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 0;
    endcase
  endfunction

  task run_random(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 20));
      end
      send_radius(rand_radius());
      burst--;
    end
  endtask

  initial begin : stimulus
    logic [31:0] directed[$];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
                 32'h0000_8000, 32'h0002_0000, 32'h0000_FFFF, 32'h7FFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (directed[i]) send_radius(directed[i]);
    wait_drained();

    write_reg(int'(srta_pkg::REG_COEF0), 32'h8000_0000);
    write_reg(int'(srta_pkg::REG_COEF0) + 1, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_radius(directed[i]);
    wait_drained();
    write_reg(int'(srta_pkg::REG_FOCAL), 0);
    send_radius(32'h0001_0000);
    send_radius(32'hFFFF_FFFF);
    wait_drained();
    write_reg(int'(srta_pkg::REG_FOCAL), 32'hFFFF_FFFF);
    write_reg(int'(srta_pkg::REG_REF), 0);
    send_radius(32'h0001_0000);
    wait_drained();
    write_reg(int'(srta_pkg::REG_REF), 32'hFFFF_FFFF);
    send_radius(32'hFFFF_FFFF);
    send_radius(32'h0);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(int'(srta_pkg::REG_FOCAL), srta_pkg::FOCAL_RESET);
          write_reg(int'(srta_pkg::REG_REF), srta_pkg::FOCAL_RESET);
          for (int k = 0; k < srta_pkg::MAX_COEFFS; k++)
            write_reg(int'(srta_pkg::REG_COEF0) + k, 0);
        end
        1: begin
          write_reg(int'(srta_pkg::REG_FOCAL), 32'hFFFF_FFFF);
          write_reg(int'(srta_pkg::REG_REF), 32'h0000_0001);
        end
        2: begin
          write_reg(int'(srta_pkg::REG_FOCAL), 32'h0000_0001);
          write_reg(int'(srta_pkg::REG_REF), 32'hFFFF_FFFF);
          for (int k = 0; k < srta_pkg::MAX_COEFFS; k++)
            write_reg(int'(srta_pkg::REG_COEF0) + k,
                      (k % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        default: begin
          write_reg(int'(srta_pkg::REG_FOCAL), ($urandom_range(0, 7) == 0) ? 0 : rand_radius());
          write_reg(int'(srta_pkg::REG_REF), ($urandom_range(0, 7) == 0) ? 0 :
                    $urandom_range(32'h0000_4000, 32'h0004_0000));
          for (int k = 0; k < srta_pkg::MAX_COEFFS; k++)
            write_reg(int'(srta_pkg::REG_COEF0) + k, rand_coef());
        end
      endcase
      if (phase == 1) begin
        hold_req = 1;
        run_random(150);
        wait_drained();
      end
      run_random(280);
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/srta_pkg.sv
src/srta_fifo.sv
src/srta_div.sv
src/srta_mul.sv
src/srta_cordic.sv
src/srta_back.sv
src/stereographic_radius_to_angle_core.sv
tb/sv/tb_stereographic_radius_to_angle_core.sv
